// ----- rtl/pi_force_motor_drive_defines.svh -----
// Assertion macros used by the RTL file pi_force_motor_drive.sv.
`ifndef PI_FORCE_MOTOR_DRIVE_DEFINES_SVH
`define PI_FORCE_MOTOR_DRIVE_DEFINES_SVH
`ifndef SYNTHESIS
// Checked outside reset only.
`define PFMD_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("pfmd assertion failed");
// Checked on every edge, reset included.
`define PFMD_ASSERT_ANY(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("pfmd assertion failed");
`else
`define PFMD_ASSERT_RST(lbl, prop)
`define PFMD_ASSERT_ANY(lbl, prop)
`endif
`endif

// ----- rtl/pfmd_pkg.sv -----
package pfmd_pkg;

  localparam int unsigned SAMPLE_W   = 8;
  localparam int unsigned GAIN_W     = 8;
  localparam int unsigned LIMIT_W    = 15;
  localparam int unsigned DUTY_W     = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_KP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DMAX  = 2'd3;

  // Micro-operations of the control program.
  localparam int unsigned OP_W = 3;
  localparam logic [OP_W-1:0] OP_NOP = 3'd0;
  localparam logic [OP_W-1:0] OP_ERR = 3'd1;
  localparam logic [OP_W-1:0] OP_SUM = 3'd2;
  localparam logic [OP_W-1:0] OP_DRV = 3'd3;
  localparam logic [OP_W-1:0] OP_MAG = 3'd4;
  localparam logic [OP_W-1:0] OP_DIV = 3'd5;
  localparam logic [OP_W-1:0] OP_OUT = 3'd6;
  localparam logic [OP_W-1:0] OP_CLR = 3'd7;

  typedef struct packed {
    logic            busy;
    logic            run;
    logic [OP_W-1:0] op;
  } ctrl_t;

  typedef struct packed {
    logic enable;
    logic sat;
    logic hold;
  } stat_t;

endpackage

// ----- rtl/pfmd_in_if.sv -----
interface pfmd_in_if;
  import pfmd_pkg::*;

  logic                valid;
  logic                ready;
  logic                enable;
  logic [SAMPLE_W-1:0] force_sample;
  logic [SAMPLE_W-1:0] current_sample;

  modport source (output valid, enable, force_sample, current_sample, input ready);
  modport sink   (input valid, enable, force_sample, current_sample, output ready);
endinterface

// ----- rtl/pfmd_out_if.sv -----
interface pfmd_out_if;
  import pfmd_pkg::*;

  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] duty;
  logic              direction;

  modport source (output valid, duty, direction, input ready);
  modport sink   (input valid, duty, direction, output ready);
endinterface

// ----- rtl/pfmd_seq.sv -----
module pfmd_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  pfmd_pkg::stat_t stat_i,
  output pfmd_pkg::ctrl_t ctrl_o
);
  import pfmd_pkg::*;

  localparam int unsigned STEP_W = 3;

  localparam logic [1:0] COND_NONE = 2'd0;
  localparam logic [1:0] COND_DIS  = 2'd1;
  localparam logic [1:0] COND_SAT  = 2'd2;

  localparam logic [STEP_W-1:0] STEP_OUT = 3'd5;
  localparam logic [STEP_W-1:0] STEP_CLR = 3'd6;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [1:0]        cond;
    logic [STEP_W-1:0] target;
    logic              last;
  } word_t;

  // Control store: one word per step.
  function automatic word_t rom(input logic [STEP_W-1:0] s);
    word_t w;
    case (s)
      3'd0:    w = '{op: OP_ERR, cond: COND_DIS,  target: STEP_CLR, last: 1'b0};
      3'd1:    w = '{op: OP_SUM, cond: COND_NONE, target: '0,       last: 1'b0};
      3'd2:    w = '{op: OP_DRV, cond: COND_NONE, target: '0,       last: 1'b0};
      3'd3:    w = '{op: OP_MAG, cond: COND_SAT,  target: STEP_OUT, last: 1'b0};
      3'd4:    w = '{op: OP_DIV, cond: COND_NONE, target: '0,       last: 1'b0};
      3'd5:    w = '{op: OP_OUT, cond: COND_NONE, target: '0,       last: 1'b1};
      3'd6:    w = '{op: OP_CLR, cond: COND_NONE, target: '0,       last: 1'b1};
      default: w = '{op: OP_NOP, cond: COND_NONE, target: '0,       last: 1'b1};
    endcase
    return w;
  endfunction

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] step_q, step_d;
  word_t             word;
  logic              stall;
  logic              take;

  assign word  = rom(step_q);
  assign stall = (word.op == OP_OUT) && stat_i.hold;
  assign take  = ((word.cond == COND_DIS) && !stat_i.enable) ||
                 ((word.cond == COND_SAT) && stat_i.sat);

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        step_d = '0;
      end
    end else if (!stall) begin
      if (word.last) begin
        busy_d = 1'b0;
      end else if (take) begin
        step_d = word.target;
      end else begin
        step_d = step_q + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  assign ctrl_o.busy = busy_q;
  assign ctrl_o.run  = busy_q && !stall;
  assign ctrl_o.op   = word.op;

endmodule

// ----- rtl/pi_force_motor_drive.sv -----
// PI motor drive toward a force target.
// Input channel in_i carries one control sample per beat: an enable bit, a
// force reading and a motor current reading. Output channel out_o carries one
// beat per enabled sample: the PWM duty value and the drive direction. A
// sample with enable low clears the integral and gives no output beat.
// A small microcode sequencer runs each sample through a shared datapath,
// one step per cycle unless the output step stalls: error, integral clamp,
// drive multiply-accumulate, magnitude, reciprocal divide and output, the
// divide skipped on drive saturation; a disabled sample runs the error
// step, then a step clearing the integral. A new sample is accepted only
// when idle, from the cycle after the last step on. The output register
// frees the sequencer from the receiver: a stall on out_o holds only the
// output step of the following sample. Reset clears the integral, empties
// the output register and restores the gains (10 and 1), the integral
// limit (1000) and duty_max (1999). Registers are written by the user
// through cfg_we_i/cfg_idx_i/cfg_data_i only while idle; not enforced here.
`include "pi_force_motor_drive_defines.svh"

module pi_force_motor_drive #(
  parameter int unsigned SAMPLE_BITS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  pfmd_in_if.sink                           in_i,
  pfmd_out_if.source                        out_o,
  input  logic                              cfg_we_i,
  input  logic [pfmd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pfmd_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import pfmd_pkg::*;

  localparam int unsigned ERR_W     = 10;
  localparam int unsigned SUM_W     = 16;
  localparam int unsigned ACC_W     = SUM_W + 1 + GAIN_W + 1;
  localparam int unsigned MAG_W     = 14;
  localparam int unsigned SPAN_W    = 11;
  localparam int unsigned X_W       = 24;
  localparam int unsigned RECIP_W   = 25;
  localparam int unsigned NUM_W     = 9;
  localparam int unsigned P_W       = SAMPLE_W + NUM_W;
  // The quotient stays below four, so two restoring steps cover it.
  localparam int unsigned CMP_W     = SAMPLE_BITS + 9;
  localparam int unsigned DEN_INT   = 100 * (2 ** SAMPLE_BITS);
  localparam logic [CMP_W-1:0]   DEN     = CMP_W'(DEN_INT);
  localparam logic [CMP_W-1:0]   DEN2    = CMP_W'(2 * DEN_INT);
  localparam logic [NUM_W-1:0]   SETP_NUM = 9'd322;
  localparam logic [SPAN_W-1:0]  DUTY_SPAN = 11'd2000;
  // Any magnitude at or above this gives a duty beyond 16 bits.
  localparam logic [ACC_W-1:0]   SAT_MAG = ACC_W'(8356);
  // ceil(2^32 / 255): exact floor division for all dividends below 2^24.
  localparam logic [RECIP_W-1:0] RECIP   = 25'd16843010;
  localparam int unsigned RECIP_SHIFT    = 32;

  ctrl_t ctrl;
  stat_t stat;
  logic  accept;

  // Configuration registers.
  logic [GAIN_W-1:0]  kp_q, ki_q;
  logic [LIMIT_W-1:0] lim_q;
  logic [DUTY_W-1:0]  dm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q  <= GAIN_W'(10);
      ki_q  <= GAIN_W'(1);
      lim_q <= LIMIT_W'(1000);
      dm_q  <= DUTY_W'(1999);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KP:    kp_q  <= cfg_data_i[GAIN_W-1:0];
        REG_KI:    ki_q  <= cfg_data_i[GAIN_W-1:0];
        REG_LIMIT: lim_q <= cfg_data_i[LIMIT_W-1:0];
        REG_DMAX:  dm_q  <= cfg_data_i[DUTY_W-1:0];
        default:   ;
      endcase
    end
  end

  assign in_i.ready = !ctrl.busy;
  assign accept     = in_i.valid && in_i.ready;

  // Sample registers.
  logic                en_q;
  logic [SAMPLE_W-1:0] force_q, cur_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b0;
    end else if (accept) begin
      en_q <= in_i.enable;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      force_q <= in_i.force_sample;
      cur_q   <= in_i.current_sample;
    end
  end

  // Setpoint and error.
  logic [P_W-1:0]   prod_f;
  logic [CMP_W-1:0] pw, rem;
  logic             q1, q0;
  logic signed [ERR_W-1:0] err_d, err_q;

  assign prod_f = P_W'(force_q) * P_W'(SETP_NUM);
  assign pw     = CMP_W'(prod_f);
  assign q1     = (pw >= DEN2);
  assign rem    = q1 ? (pw - DEN2) : pw;
  assign q0     = (rem >= DEN);
  assign err_d  = ERR_W'({q1, q0}) - ERR_W'(cur_q);

  // Integral with clamp.
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic signed [SUM_W:0]   sum_ext, lim_ext, lim_neg;

  assign sum_ext = {sum_q[SUM_W-1], sum_q} +
                   {{(SUM_W+1-ERR_W){err_q[ERR_W-1]}}, err_q};
  assign lim_ext = {2'b00, lim_q};
  assign lim_neg = -lim_ext;

  always_comb begin
    if (sum_ext > lim_ext) begin
      sum_d = lim_ext[SUM_W-1:0];
    end else if (sum_ext < lim_neg) begin
      sum_d = lim_neg[SUM_W-1:0];
    end else begin
      sum_d = sum_ext[SUM_W-1:0];
    end
  end

  // Shared gain multiplier.
  logic signed [SUM_W:0]    ma;
  logic signed [GAIN_W:0]   mb;
  logic signed [ACC_W-1:0]  prod_g, acc_q;

  assign ma = (ctrl.op == OP_DRV) ? {sum_q[SUM_W-1], sum_q}
                                  : {{(SUM_W+1-ERR_W){err_q[ERR_W-1]}}, err_q};
  assign mb = {1'b0, (ctrl.op == OP_DRV) ? ki_q : kp_q};
  assign prod_g = ACC_W'(ma) * ACC_W'(mb);

  // Magnitude and scaling.
  logic [ACC_W-1:0]          mag;
  logic [MAG_W+SPAN_W-1:0]   prod_x;
  logic [X_W-1:0]            x_q;
  logic                      sat_q;
  logic [X_W+RECIP_W-1:0]    prod_r;
  logic [DUTY_W-1:0]         quo_q;

  assign mag    = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
  assign prod_x = {{SPAN_W{1'b0}}, mag[MAG_W-1:0]} * {{MAG_W{1'b0}}, DUTY_SPAN};
  assign prod_r = {{RECIP_W{1'b0}}, x_q} * {{X_W{1'b0}}, RECIP};

  always_ff @(posedge clk_i) begin
    if (ctrl.run) begin
      case (ctrl.op)
        OP_ERR:  err_q <= err_d;
        OP_SUM:  acc_q <= prod_g;
        OP_DRV:  acc_q <= acc_q + prod_g;
        OP_MAG: begin
          x_q   <= prod_x[X_W-1:0];
          sat_q <= (mag >= SAT_MAG);
        end
        OP_DIV:  quo_q <= prod_r[RECIP_SHIFT+DUTY_W-1:RECIP_SHIFT];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (ctrl.run && (ctrl.op == OP_SUM)) begin
      sum_q <= sum_d;
    end else if (ctrl.run && (ctrl.op == OP_CLR)) begin
      sum_q <= '0;
    end
  end

  // Output register.
  logic              out_valid_q;
  logic [DUTY_W-1:0] duty_q;
  logic              dir_q;
  logic              load_out;

  assign load_out = ctrl.run && (ctrl.op == OP_OUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      duty_q <= (sat_q || (quo_q > dm_q)) ? dm_q : quo_q;
      dir_q  <= (err_q > 0);
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.duty      = duty_q;
  assign out_o.direction = dir_q;

  assign stat.enable = en_q;
  assign stat.sat    = (mag >= SAT_MAG);
  assign stat.hold   = out_valid_q && !out_o.ready;

  pfmd_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .stat_i  (stat),
    .ctrl_o  (ctrl)
  );

  `PFMD_ASSERT_RST(a_start_err, accept |=> (ctrl.run && (ctrl.op == OP_ERR)))
  `PFMD_ASSERT_RST(a_out_from_step, $rose(out_valid_q) |-> $past(load_out))
  `PFMD_ASSERT_RST(a_sat_duty, (load_out && sat_q) |=> (duty_q == $past(dm_q)))
  `PFMD_ASSERT_ANY(a_stall_holds,
    (ctrl.busy && (ctrl.op == OP_OUT) && stat.hold && rst_ni) |=> (ctrl.op == OP_OUT))

endmodule

// ----- verif/tb_pi_force_motor_drive.sv -----
`timescale 1ns / 100ps

module tb_pi_force_motor_drive;
  import pfmd_pkg::*;

  localparam int unsigned CLK_PERIOD    = 12;
  localparam int unsigned NUM_PHASES    = 8;
  localparam int unsigned PHASE_SAMPLES = 66;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam longint      SET_NUM       = 322;
  localparam longint      SET_DEN       = 100 << SAMPLE_W;
  localparam longint      DUTY_SPAN     = 2000;
  localparam longint      DRIVE_SPAN    = 255;
  localparam int unsigned NUM_ROWS      = 30;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              direction;
  } drive_t;

  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic                  enable;
    logic [SAMPLE_W-1:0]   force_v;
    logic [SAMPLE_W-1:0]   current_v;
    bit                    typed;
    drive_t                drive;
  } step_row_t;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  pfmd_in_if  in_if ();
  pfmd_out_if out_if ();

  pi_force_motor_drive i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Register and integral copy of the controller.
  logic [GAIN_W-1:0]  kp_q = 8'd10;
  logic [GAIN_W-1:0]  ki_q = 8'd1;
  logic [LIMIT_W-1:0] limit_q = 15'd1000;
  logic [DUTY_W-1:0]  dmax_q = 16'd1999;
  longint             isum_q = 0;

  drive_t      drive_q [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned calm_samples = 0;

  // Directed sweep: item extremes, setpoint edges, integral clamp and register extremes.
  step_row_t step_tab [NUM_ROWS] = '{
    '{1'b0, REG_KP,    16'h0000, 1'b1, 8'd0,   8'd0,   1'b1, {16'd0, 1'b0}},
    '{1'b0, REG_KP,    16'h0000, 1'b1, 8'd255, 8'd0,   1'b1, {16'd258, 1'b1}},
    '{1'b0, REG_KP,    16'h0000, 1'b0, 8'd255, 8'd255, 1'b0, 17'd0},
    '{1'b0, REG_KP,    16'h0000, 1'b1, 8'd0,   8'd255, 1'b1, {16'd1999, 1'b0}},
    '{1'b0, REG_KP,    16'h0000, 1'b1, 8'd0,   8'd255, 1'b0, 17'd0},
    '{1'b0, REG_KP,    16'h0000, 1'b1, 8'd0,   8'd255, 1'b0, 17'd0},
    '{1'b0, REG_KP,    16'h0000, 1'b1, 8'd0,   8'd255, 1'b0, 17'd0},
    '{1'b0, REG_KP,    16'h0000, 1'b1, 8'd0,   8'd255, 1'b0, 17'd0},
    '{1'b0, REG_KP,    16'h0000, 1'b1, 8'd255, 8'd3,   1'b0, 17'd0},
    '{1'b0, REG_KP,    16'h0000, 1'b1, 8'd80,  8'd1,   1'b0, 17'd0},
    '{1'b0, REG_KP,    16'h0000, 1'b1, 8'd79,  8'd0,   1'b0, 17'd0},
    '{1'b0, REG_KP,    16'h0000, 1'b0, 8'd0,   8'd0,   1'b0, 17'd0},
    '{1'b1, REG_DMAX,  16'hFFFF, 1'b0, 8'd0,   8'd0,   1'b0, 17'd0},
    '{1'b1, REG_LIMIT, 16'h0000, 1'b0, 8'd0,   8'd0,   1'b0, 17'd0},
    '{1'b0, REG_KP,    16'h0000, 1'b1, 8'd0,   8'd255, 1'b1, {16'd20000, 1'b0}},
    '{1'b0, REG_KP,    16'h0000, 1'b1, 8'd255, 8'd0,   1'b1, {16'd235, 1'b1}},
    '{1'b1, REG_KP,    16'hFFFF, 1'b0, 8'd0,   8'd0,   1'b0, 17'd0},
    '{1'b1, REG_KI,    16'hFFFF, 1'b0, 8'd0,   8'd0,   1'b0, 17'd0},
    '{1'b1, REG_LIMIT, 16'hFFFF, 1'b0, 8'd0,   8'd0,   1'b0, 17'd0},
    '{1'b0, REG_KP,    16'h0000, 1'b0, 8'd0,   8'd0,   1'b0, 17'd0},
    '{1'b0, REG_KP,    16'h0000, 1'b1, 8'd0,   8'd255, 1'b1, {16'd65535, 1'b0}},
    '{1'b0, REG_KP,    16'h0000, 1'b1, 8'd170, 8'd2,   1'b0, 17'd0},
    '{1'b1, REG_KP,    16'h0000, 1'b0, 8'd0,   8'd0,   1'b0, 17'd0},
    '{1'b1, REG_KI,    16'h0000, 1'b0, 8'd0,   8'd0,   1'b0, 17'd0},
    '{1'b0, REG_KP,    16'h0000, 1'b1, 8'd255, 8'd0,   1'b1, {16'd0, 1'b1}},
    '{1'b1, REG_DMAX,  16'h0000, 1'b0, 8'd0,   8'd0,   1'b0, 17'd0},
    '{1'b1, REG_KP,    16'h00AA, 1'b0, 8'd0,   8'd0,   1'b0, 17'd0},
    '{1'b1, REG_KI,    16'h0055, 1'b0, 8'd0,   8'd0,   1'b0, 17'd0},
    '{1'b0, REG_KP,    16'h0000, 1'b1, 8'd255, 8'd1,   1'b1, {16'd0, 1'b1}},
    '{1'b0, REG_KP,    16'h0000, 1'b1, 8'd0,   8'd128, 1'b0, 17'd0}
  };

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("pi_force_motor_drive verification failed");
      $finish;
    end
  end

  function automatic void set_reg(input logic [CFG_IDX_W-1:0]  idx,
                                  input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_KP:    kp_q = data[GAIN_W-1:0];
      REG_KI:    ki_q = data[GAIN_W-1:0];
      REG_LIMIT: limit_q = data[LIMIT_W-1:0];
      REG_DMAX:  dmax_q = data[DUTY_W-1:0];
      default: ;
    endcase
  endfunction

  // One control step; returns whether the sample produces a drive beat.
  function automatic bit pi_step(input logic enable, input logic [SAMPLE_W-1:0] force_v,
                                 input logic [SAMPLE_W-1:0] current_v, output drive_t res);
    longint err, lim, drv, mag, duty;
    res = '0;
    if (!enable) begin
      isum_q = 0;
      return 1'b0;
    end
    err = longint'(force_v) * SET_NUM / SET_DEN - longint'(current_v);
    lim = longint'(limit_q);
    isum_q = isum_q + err;
    if (isum_q > lim) begin
      isum_q = lim;
    end else if (isum_q < -lim) begin
      isum_q = -lim;
    end
    drv = longint'(kp_q) * err + longint'(ki_q) * isum_q;
    mag = (drv < 0) ? -drv : drv;
    duty = mag * DUTY_SPAN / DRIVE_SPAN;
    if (duty > longint'(dmax_q)) begin
      duty = longint'(dmax_q);
    end
    res.duty = duty[DUTY_W-1:0];
    res.direction = (err > 0);
    return 1'b1;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm_samples > 0) begin
      calm_samples--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_samples = $urandom_range(20, 60);
    end
    if (r < 55) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // Valid stays high across back-to-back beats; it drops only for a gap here and in settle().
  task automatic send_sample(input logic enable, input logic [SAMPLE_W-1:0] force_v,
                             input logic [SAMPLE_W-1:0] current_v, input bit typed,
                             input drive_t typed_res);
    int unsigned gap;
    drive_t      res;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.enable         <= enable;
    in_if.force_sample   <= force_v;
    in_if.current_sample <= current_v;
    do @(posedge clk_i); while (!in_if.ready);
    if (pi_step(enable, force_v, current_v, res)) begin
      drive_q.push_back(typed ? typed_res : res);
    end
  endtask

  // A disabled sample gives no beat, so wait out its processing after the queue drains.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    set_reg(idx, data);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_phase(input int unsigned phase);
    logic [CFG_DATA_W-1:0] kp_d, ki_d, lim_d, dmax_d;
    kp_d   = CFG_DATA_W'($urandom);
    ki_d   = $urandom_range(0, 1) ? CFG_DATA_W'($urandom) : CFG_DATA_W'($urandom_range(0, 8));
    lim_d  = {1'($urandom_range(0, 1)), 15'($urandom_range(0, 3000))};
    dmax_d = $urandom_range(0, 1) ? CFG_DATA_W'($urandom) : CFG_DATA_W'($urandom_range(0, 3000));
    case (phase)
      0: begin
        kp_d = '0;
        ki_d = '0;
      end
      1: begin
        kp_d   = 16'h00FF;
        ki_d   = 16'h00FF;
        lim_d  = 16'h7FFF;
        dmax_d = 16'hFFFF;
      end
      2: lim_d = '0;
      3: dmax_d = '0;
      4: begin
        kp_d   = 16'd10;
        ki_d   = 16'd1;
        lim_d  = 16'd1000;
        dmax_d = 16'd1999;
      end
      default: ;
    endcase
    write_reg(REG_KP, kp_d);
    write_reg(REG_KI, ki_d);
    write_reg(REG_LIMIT, lim_d);
    write_reg(REG_DMAX, dmax_d);
  endtask

  task automatic check_drive();
    drive_t want;
    if (drive_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected beat, expected none, actual duty=%0d direction=%0b",
               $time, out_if.duty, out_if.direction);
    end else begin
      want = drive_q.pop_front();
      if (out_if.duty !== want.duty) begin
        errors++;
        $display("%0t: duty mismatch, expected %0d, actual %0d", $time, want.duty, out_if.duty);
      end
      if (out_if.direction !== want.direction) begin
        errors++;
        $display("%0t: direction mismatch, expected %0b, actual %0b",
                 $time, want.direction, out_if.direction);
      end
    end
  endtask

  // Receiver: mostly ready, with short stalls, a few long ones, and some stretches of full rate.
  initial begin
    int unsigned stall_left, calm_left, r;
    stall_left = 0;
    calm_left  = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        check_drive();
      end
      if (calm_left > 0) begin
        calm_left--;
        out_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        r = $urandom_range(0, 199);
        if (r < 2) begin
          calm_left = $urandom_range(100, 300);
          out_if.ready <= 1'b1;
        end else if (r < 60) begin
          stall_left = $urandom_range(0, 2);
          out_if.ready <= 1'b0;
        end else if (r < 70) begin
          stall_left = $urandom_range(9, 39);
          out_if.ready <= 1'b0;
        end else begin
          out_if.ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    logic                en;
    logic [SAMPLE_W-1:0] frc, cur;
    in_if.valid          <= 1'b0;
    in_if.enable         <= 1'b0;
    in_if.force_sample   <= '0;
    in_if.current_sample <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (step_tab[i]) begin
      if (step_tab[i].is_cfg) begin
        settle();
        write_reg(step_tab[i].idx, step_tab[i].data);
      end else begin
        send_sample(step_tab[i].enable, step_tab[i].force_v, step_tab[i].current_v,
                    step_tab[i].typed, step_tab[i].drive);
      end
    end

    for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
      settle();
      program_phase(phase);
      for (int unsigned n = 0; n < PHASE_SAMPLES; n++) begin
        if ($urandom_range(0, 59) == 0) begin
          settle();
        end
        // Mostly enabled runs so the integral builds up toward its clamp.
        en  = ($urandom_range(0, 99) < 92);
        frc = SAMPLE_W'($urandom);
        cur = $urandom_range(0, 1) ? SAMPLE_W'($urandom_range(0, 4)) : SAMPLE_W'($urandom);
        send_sample(en, frc, cur, 1'b0, '0);
      end
    end

    settle();
    if (errors == 0) begin
      $display("pi_force_motor_drive verification clean");
    end else begin
      $display("pi_force_motor_drive verification failed");
    end
    $finish;
  end

endmodule
